// ===== design/bse_pkg.sv =====
// ----------------------------------------------------------------------------
// bse_pkg: shared types and constants for the bounded stack engine
// Action codes, payload structs and the cell control word.
// ----------------------------------------------------------------------------
package bse_pkg;

  localparam int DEPTH = 32;
  localparam int LVL_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  localparam logic [2:0] ACT_PUSH  = 3'd0;
  localparam logic [2:0] ACT_POP   = 3'd1;
  localparam logic [2:0] ACT_REV   = 3'd2;
  localparam logic [2:0] ACT_SPUSH = 3'd3;
  localparam logic [2:0] ACT_DEL   = 3'd4;
  localparam logic [2:0] ACT_CLEAR = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_NOHIT = 2'd3;

  localparam logic signed [31:0] EMPTY_WORD = -32'sd999;

  // per-cycle command broadcast to every cell
  localparam logic [1:0] CC_HOLD  = 2'd0;
  localparam logic [1:0] CC_UP    = 2'd1;  // take word from cell below
  localparam logic [1:0] CC_DOWN  = 2'd2;  // take word from cell above
  localparam logic [1:0] CC_LOAD  = 2'd3;  // insert: tgt takes operand, rest take below

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] popped;
    logic [1:0]         status;
    logic [5:0]         removed;
    logic [5:0]         occupancy;
  } rsp_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [LVL_W-1:0]   lo;     // cells with index >= lo act
    logic [LVL_W-1:0]   hi;     // cells with index < hi act
    logic [LVL_W-1:0]   tgt;    // cell taking operand on CC_LOAD
    logic signed [31:0] opnd;
  } cell_ctl_t;

endpackage

// ===== design/bse_cell.sv =====
// ----------------------------------------------------------------------------
// bse_cell: one stack slot
// Holds one word; shifts with its neighbors or loads the operand.
// ----------------------------------------------------------------------------
module bse_cell (
  input  logic                    clk,
  input  logic [bse_pkg::LVL_W-1:0] idx,
  input  bse_pkg::cell_ctl_t      ctl,
  input  logic signed [31:0]      below,
  input  logic signed [31:0]      above,
  output logic signed [31:0]      word
);
  logic act;
  assign act = (idx >= ctl.lo) && (idx < ctl.hi);

  always_ff @(posedge clk) begin
    if (act) begin
      unique case (ctl.cmd)
        bse_pkg::CC_UP:   word <= below;
        bse_pkg::CC_DOWN: word <= above;
        bse_pkg::CC_LOAD: word <= (idx == ctl.tgt) ? ctl.opnd : below;
        default:          word <= word;
      endcase
    end
  end
endmodule

// ===== design/bounded_stack_engine.sv =====
// ----------------------------------------------------------------------------
// bounded_stack_engine: fixed-depth stack of signed words
// Cell row plus a small sequencer that walks it.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with req (action, value) while busy is low; that edge is the
//   transfer. Exactly one result appears on rsp with done high for one cycle.
//   Push, pop, clear, unused codes, refused inserts, a delete on an empty
//   stack and a reverse of fewer than two entries finish at the transfer
//   edge: done is high in the next cycle and busy never rises, so these can
//   be sent back to back. Sorted push compares one cell per cycle from the top.
//   Delete scans the same way. Reverse moves the top word down to slot k in
//   step k, n-1 steps for n entries.
//   busy is high from the transfer until the edge that raises done, so the
//   next start can be taken in the done cycle. One item is in flight.
//   The receiver cannot stall: done is a one-cycle strobe.
//   rst (sync, high) empties the stack; cell contents are not cleared and are
//   only read after written.
// ----------------------------------------------------------------------------
module bounded_stack_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  bse_pkg::req_t   req,
  output logic            busy,
  output logic            done,
  output bse_pkg::rsp_t   rsp
);
  localparam int LW = bse_pkg::LVL_W;
  localparam int IW = bse_pkg::IDX_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;  // search from top downward
  localparam logic [1:0] S_REV  = 2'd2;  // reverse by repeated insert of top

  logic [1:0]         state, state_next;
  logic [LW-1:0]      level, level_next;
  logic [LW-1:0]      ptr, ptr_next;     // scan position, one above probe
  logic [LW-1:0]      span, span_next;   // reverse step / insert slot
  logic [2:0]         act;
  logic signed [31:0] opnd;
  bse_pkg::rsp_t      rsp_next;
  logic               done_next;
  bse_pkg::cell_ctl_t ctl;
  logic signed [31:0] words [bse_pkg::DEPTH];

  genvar g;
  generate
    for (g = 0; g < bse_pkg::DEPTH; g++) begin : g_cell
      logic signed [31:0] blw, abv;
      if (g == 0) begin : g_b
        assign blw = 32'sd0;
      end else begin : g_nb
        assign blw = words[g-1];
      end
      if (g == bse_pkg::DEPTH - 1) begin : g_t
        assign abv = 32'sd0;
      end else begin : g_nt
        assign abv = words[g+1];
      end
      bse_cell u_cell (
        .clk(clk), .idx(LW'(g)), .ctl(ctl), .below(blw), .above(abv),
        .word(words[g])
      );
    end
  endgenerate

  // word at scan position ptr-1 (one compare per cycle)
  logic signed [31:0] probe;
  assign probe = words[IW'(ptr - 1'b1)];

  // current top of stack, for pop and reverse
  logic signed [31:0] top_w;
  assign top_w = words[IW'(level - 1'b1)];

  logic full, empty;
  assign full  = (level == LW'(bse_pkg::DEPTH));
  assign empty = (level == '0);
  assign busy  = (state != S_IDLE);

  always_comb begin
    state_next = state;
    level_next = level;
    ptr_next   = ptr;
    span_next  = span;
    rsp_next   = rsp;
    done_next  = 1'b0;
    ctl = '{cmd: bse_pkg::CC_HOLD, lo: '0, hi: '0, tgt: '0, opnd: '0};
    unique case (state)
      S_IDLE: if (start) begin
        rsp_next  = '0;
        done_next = 1'b1;
        unique case (req.action)
          bse_pkg::ACT_PUSH:
            if (full) rsp_next.status = bse_pkg::ST_FULL;
            else begin
              ctl.cmd = bse_pkg::CC_LOAD; ctl.lo = level; ctl.hi = level + 1'b1;
              ctl.tgt = level; ctl.opnd = req.value;
              level_next = level + 1'b1;
            end
          bse_pkg::ACT_POP:
            if (empty) begin
              rsp_next.popped = bse_pkg::EMPTY_WORD;
              rsp_next.status = bse_pkg::ST_EMPTY;
            end else begin
              rsp_next.popped = top_w;
              level_next = level - 1'b1;
            end
          bse_pkg::ACT_REV:
            if (level > LW'(1)) begin
              state_next = S_REV; span_next = '0; done_next = 1'b0;
            end
          bse_pkg::ACT_SPUSH:
            if (full) rsp_next.status = bse_pkg::ST_FULL;
            else begin
              state_next = S_SCAN; ptr_next = level; done_next = 1'b0;
            end
          bse_pkg::ACT_DEL:
            if (empty) rsp_next.status = bse_pkg::ST_EMPTY;
            else begin
              state_next = S_SCAN; ptr_next = level; done_next = 1'b0;
            end
          bse_pkg::ACT_CLEAR: begin
            rsp_next.removed = 6'(level);
            level_next = '0;
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        if (act == bse_pkg::ACT_SPUSH) begin
          if (ptr == '0 || !(probe > opnd)) begin
            // shift [ptr, level) up one and drop operand at ptr
            ctl.cmd = bse_pkg::CC_LOAD; ctl.lo = ptr; ctl.hi = level + 1'b1;
            ctl.tgt = ptr; ctl.opnd = opnd;
            level_next = level + 1'b1;
            state_next = S_IDLE; done_next = 1'b1;
          end else ptr_next = ptr - 1'b1;
        end else if (ptr == '0) begin
          rsp_next.status = bse_pkg::ST_NOHIT;
          state_next = S_IDLE; done_next = 1'b1;
        end else if (probe == opnd) begin
          // close the gap: [ptr-1, level-1) takes the word above
          ctl.cmd = bse_pkg::CC_DOWN; ctl.lo = ptr - 1'b1; ctl.hi = level - 1'b1;
          level_next = level - 1'b1;
          state_next = S_IDLE; done_next = 1'b1;
        end else ptr_next = ptr - 1'b1;
      end
      S_REV: begin
        // step k: top word goes to slot k, [k, level-1) moves up one
        ctl.cmd = bse_pkg::CC_LOAD; ctl.lo = span; ctl.hi = level;
        ctl.tgt = span; ctl.opnd = top_w;
        span_next = span + 1'b1;
        if (span + LW'(2) >= level) begin
          state_next = S_IDLE; done_next = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (done_next) rsp_next.occupancy = 6'(level_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      level <= '0;
      ptr   <= '0;
      span  <= '0;
      act   <= '0;
      opnd  <= '0;
      rsp   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      level <= level_next;
      ptr   <= ptr_next;
      span  <= span_next;
      rsp   <= rsp_next;
      done  <= done_next;
      if (state == S_IDLE && start) begin
        act  <= req.action;
        opnd <= req.value;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy);
  a_level_max: assert property (@(posedge clk) disable iff (rst)
                                level <= LW'(bse_pkg::DEPTH));
  a_busy_done: assert property (@(posedge clk) disable iff (rst) $fell(busy) |-> done);
`endif

endmodule

// ===== bench/bounded_stack_engine_tb.sv =====
// ----------------------------------------------------------------------------
// bounded_stack_engine_tb: self-checking bench for the bounded stack engine
// Drives push/pop/reverse/sorted push/delete/clear commands with random
// gaps, predicts each response with a behavioral stack and compares fields.
// ----------------------------------------------------------------------------
module bounded_stack_engine_tb;

  localparam int WATCHDOG_LIMIT = 20000;

  // Expected responses plus a behavioral copy of the stack.
  class stack_scoreboard;
    logic signed [31:0] words[bse_pkg::DEPTH];
    int                 level;
    bse_pkg::rsp_t      pending[$];
    int                 mismatches;

    function new();
      level      = 0;
      mismatches = 0;
    endfunction

    // Work out the response of one accepted command and queue it.
    function void note_command(bse_pkg::req_t r);
      bse_pkg::rsp_t      e;
      int                 pos;
      int                 lo;
      int                 hi;
      bit                 hit;
      logic signed [31:0] t;
      logic signed [31:0] v;
      e = '0;
      v = r.value;
      case (r.action)
        bse_pkg::ACT_PUSH: begin
          if (level >= bse_pkg::DEPTH) e.status = bse_pkg::ST_FULL;
          else begin
            words[level] = v;
            level++;
          end
        end
        bse_pkg::ACT_POP: begin
          if (level == 0) begin
            e.popped = bse_pkg::EMPTY_WORD;
            e.status = bse_pkg::ST_EMPTY;
          end else begin
            level--;
            e.popped = words[level];
          end
        end
        bse_pkg::ACT_REV: begin
          lo = 0;
          hi = level - 1;
          while (lo < hi) begin
            t         = words[lo];
            words[lo] = words[hi];
            words[hi] = t;
            lo++;
            hi--;
          end
        end
        bse_pkg::ACT_SPUSH: begin
          if (level >= bse_pkg::DEPTH) e.status = bse_pkg::ST_FULL;
          else begin
            // slide below the run of strictly greater words at the top
            pos = level;
            while (pos > 0 && words[pos-1] > v) pos--;
            for (int i = level; i > pos; i--) words[i] = words[i-1];
            words[pos] = v;
            level++;
          end
        end
        bse_pkg::ACT_DEL: begin
          if (level == 0) e.status = bse_pkg::ST_EMPTY;
          else begin
            hit = 0;
            pos = level;
            while (pos > 0 && !hit) begin
              pos--;
              if (words[pos] == v) hit = 1;
            end
            if (!hit) e.status = bse_pkg::ST_NOHIT;
            else begin
              for (int i = pos; i + 1 < level; i++) words[i] = words[i+1];
              level--;
            end
          end
        end
        bse_pkg::ACT_CLEAR: begin
          e.removed = 6'(level);
          level     = 0;
        end
        default: ;  // unused codes change nothing
      endcase
      e.occupancy = 6'(level);
      pending.push_back(e);
    endfunction

    function void check_response(bse_pkg::rsp_t got);
      bse_pkg::rsp_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", got);
        return;
      end
      e = pending.pop_front();
      if (got.popped !== e.popped || got.status !== e.status ||
          got.removed !== e.removed || got.occupancy !== e.occupancy) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp popped=%0d st=%0d rm=%0d occ=%0d, %s%0d st=%0d rm=%0d occ=%0d",
                   e.popped, e.status, e.removed, e.occupancy, "got popped=",
                   got.popped, got.status, got.removed, got.occupancy);
      end
    endfunction
  endclass

  logic           clk = 0;
  logic           rst = 1;
  logic           start = 0;
  bse_pkg::req_t  req = '0;
  logic           busy, done;
  bse_pkg::rsp_t  rsp;

  stack_scoreboard sb = new();
  int    send_gap_pct = 23;
  int    idle_cycles  = 0;

  bounded_stack_engine u_dut (
    .clk(clk), .rst(rst), .start(start), .req(req),
    .busy(busy), .done(done), .rsp(rsp)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // Response monitor and watchdog: both sample at the edge that ends a cycle.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_response(rsp);
      if (done || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[bounded_stack_engine] ERROR");
        $finish;
      end
    end
  end

  // Issue one command: optional random gap, then hold start until transfer.
  task automatic send_command(logic [2:0] act, logic signed [31:0] val);
    bse_pkg::req_t r;
    r.action = act;
    r.value  = val;
    while ($urandom_range(99) < send_gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    sb.note_command(r);
  endtask

  // Half of the values are small so deletes hit and sorted pushes see ties.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(16)) - 8;
    endcase
  endfunction

  task automatic random_phase(int count);
    int r;
    logic [2:0] act;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      // bias toward fills so the full boundary is reached often
      if (r < 30) act = bse_pkg::ACT_PUSH;
      else if (r < 50) act = bse_pkg::ACT_SPUSH;
      else if (r < 65) act = bse_pkg::ACT_POP;
      else if (r < 82) act = bse_pkg::ACT_DEL;
      else if (r < 90) act = bse_pkg::ACT_REV;
      else if (r < 95) act = bse_pkg::ACT_CLEAR;
      else act = 3'($urandom_range(7));
      send_command(act, pick_value());
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty cases, extremes, every action, unused codes
    send_command(bse_pkg::ACT_POP, 0);
    send_command(bse_pkg::ACT_DEL, 5);
    send_command(bse_pkg::ACT_REV, 0);
    send_command(bse_pkg::ACT_CLEAR, 0);
    send_command(bse_pkg::ACT_PUSH, 32'sh7fffffff);
    send_command(bse_pkg::ACT_REV, 0);
    send_command(bse_pkg::ACT_PUSH, 32'sh80000000);
    send_command(bse_pkg::ACT_SPUSH, 0);
    send_command(bse_pkg::ACT_SPUSH, 0);
    send_command(bse_pkg::ACT_SPUSH, -1);
    send_command(bse_pkg::ACT_DEL, 12345);
    send_command(bse_pkg::ACT_DEL, 0);
    send_command(bse_pkg::ACT_REV, 0);
    send_command(3'd6, -1);
    send_command(3'd7, -1);
    send_command(bse_pkg::ACT_POP, 0);
    send_command(bse_pkg::ACT_CLEAR, 0);
    // fill to the brim, then both refused inserts
    for (int i = 0; i < bse_pkg::DEPTH; i++) send_command(bse_pkg::ACT_SPUSH, $urandom);
    send_command(bse_pkg::ACT_PUSH, 1);
    send_command(bse_pkg::ACT_SPUSH, 1);
    send_command(bse_pkg::ACT_REV, 0);
    send_command(bse_pkg::ACT_CLEAR, 0);

    // pause until every response has come back
    drain();

    random_phase(330);
    send_gap_pct = 47;
    random_phase(330);
    send_gap_pct = 0;
    random_phase(330);

    drain();
    repeat (2 * bse_pkg::DEPTH + 10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("[bounded_stack_engine] OK");
    else
      $display("[bounded_stack_engine] ERROR");
    $finish;
  end
endmodule

// ===== bounded_stack_engine.f =====
design/bse_pkg.sv
design/bse_cell.sv
design/bounded_stack_engine.sv
bench/bounded_stack_engine_tb.sv
